FILE: src/mbrs_pkg.sv
package mbrs_pkg;

   localparam int WORD_BITS     = 64;
   localparam int GRAIN_SHIFT   = 3;
   localparam int WORD_SHIFT    = 6;
   localparam int ADDR_W        = 48;
   localparam int SIZE_W        = 20;
   localparam int CSR_INDEX_W   = 1;
   localparam int DEF_BITMAP_WORDS = 1024;
   localparam logic [SIZE_W-1:0] HEAP_BYTES_RESET = 20'd524288;
   localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

   typedef enum logic [1:0] {
      CMD_MARK  = 2'd0,
      CMD_TEST  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MISALIGN  = 2'd1,
      ST_RANGE     = 2'd2,
      ST_ALREADY   = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEAP_BASE  = 1'd0,
      CSR_HEAP_BYTES = 1'd1
   } csr_index_type;

endpackage

FILE: src/mbrs_req_if.sv
interface mbrs_req_if import mbrs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [ADDR_W-1:0] obj_addr;
   logic [SIZE_W-1:0] obj_bytes;

   modport source (output valid, cmd, obj_addr, obj_bytes, input ready);
   modport sink   (input valid, cmd, obj_addr, obj_bytes, output ready);
endinterface

FILE: src/mbrs_rsp_if.sv
interface mbrs_rsp_if;
   logic       valid;
   logic       ready;
   logic       marked;
   logic [1:0] status;

   modport source (output valid, marked, status, input ready);
   modport sink   (input valid, marked, status, output ready);
endinterface

FILE: src/mbrs_ram.sv
module mbrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mark_bitmap_range_setter.sv
// A test in range reads its word (CALC, TRD); one out of range answers marked from CALC.
// A mark checks its range (CALC, RANGE) and reads the first end word (RD1), writing it there
// if it is the only one; else it reads and writes the last (RD2), then the first (WR1) and
// the middle words (FILL). A clear writes every word; a no-op goes straight to DONE. One
// request is in work at a time; a held response adds its wait. Reset is synchronous; after
// it the bitmap is cleared before any request. Configuration writes are taken at any time.
module mark_bitmap_range_setter import mbrs_pkg::*; #(
   parameter int BITMAP_WORDS = DEF_BITMAP_WORDS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]      csr_wdata,
   mbrs_req_if.sink               req_ch,
   mbrs_rsp_if.source             rsp_ch
);

   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int BIT_W = ADDR_W - GRAIN_SHIFT;
   localparam int LAST_W = BIT_W + 1;
   localparam int NB_W = SIZE_W - GRAIN_SHIFT;
   localparam logic [LAST_W-1:0] TOTAL_BITS = LAST_W'(BITMAP_WORDS * WORD_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_CALC  = 10'b0000000100,
      S_RANGE = 10'b0000001000,
      S_RD1   = 10'b0000010000,
      S_RD2   = 10'b0000100000,
      S_WR1   = 10'b0001000000,
      S_FILL  = 10'b0010000000,
      S_TRD   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   heap_base_ff, heap_base_in;
   logic [SIZE_W-1:0]   heap_bytes_ff, heap_bytes_in;
   cmd_type             cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic                below_ff, below_in;
   logic                size_bad_ff, size_bad_in;
   logic [NB_W-1:0]     nbm1_ff, nbm1_in;
   logic [LAST_W-1:0]   last_ff, last_in;
   logic [WORD_BITS-1:0] word1_ff, word1_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                clr_reply_ff, clr_reply_in;
   logic                res_marked_ff, res_marked_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_marked_ff, rsp_marked_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [ADDR_W:0]      diff;
   logic [AW-1:0]        fw;
   logic [AW-1:0]        lw;
   logic [WORD_BITS-1:0] m1, m2, m_first;
   logic                 one_word;
   logic                 outside;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

   mbrs_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (BITMAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign diff     = {1'b0, req_ch.obj_addr} - {1'b0, heap_base_ff};
   assign fw       = off_ff[AW+GRAIN_SHIFT+WORD_SHIFT-1:GRAIN_SHIFT+WORD_SHIFT];
   assign lw       = last_ff[AW+WORD_SHIFT-1:WORD_SHIFT];
   assign one_word = (fw == lw);
   assign m1       = ALL_ONES << off_ff[GRAIN_SHIFT+WORD_SHIFT-1:GRAIN_SHIFT];
   assign m2       = ALL_ONES >> (6'd63 - last_ff[WORD_SHIFT-1:0]);
   assign m_first  = one_word ? (m1 & m2) : m1;
   assign outside  = below_ff || (off_ff >= ADDR_W'(heap_bytes_ff))
                     || (LAST_W'(off_ff[ADDR_W-1:GRAIN_SHIFT]) >= TOTAL_BITS);

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.marked = rsp_marked_ff;
   assign rsp_ch.status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      heap_base_in  = heap_base_ff;
      heap_bytes_in = heap_bytes_ff;
      cmd_in        = cmd_ff;
      off_in        = off_ff;
      below_in      = below_ff;
      size_bad_in   = size_bad_ff;
      nbm1_in       = nbm1_ff;
      last_in       = last_ff;
      word1_in      = word1_ff;
      cnt_in        = cnt_ff;
      clr_reply_in  = clr_reply_ff;
      res_marked_in = res_marked_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_marked_in = rsp_marked_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff;
      ram_wdata     = '0;
      ram_raddr     = fw;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HEAP_BASE:  heap_base_in  = csr_wdata;
            CSR_HEAP_BYTES: heap_bytes_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = '0;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == LAST_WORD) begin
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in        = cmd_type'(req_ch.cmd);
               off_in        = diff[ADDR_W-1:0];
               below_in      = diff[ADDR_W];
               size_bad_in   = (req_ch.obj_bytes == '0)
                               || (req_ch.obj_bytes[GRAIN_SHIFT-1:0] != '0);
               nbm1_in       = req_ch.obj_bytes[SIZE_W-1:GRAIN_SHIFT] - 1'b1;
               res_marked_in = 1'b0;
               res_status_in = ST_OK;
               case (cmd_type'(req_ch.cmd))
                  CMD_MARK, CMD_TEST: state_in = S_CALC;
                  CMD_CLEAR: begin
                     cnt_in       = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CALC: begin
            if (cmd_ff == CMD_TEST) begin
               if (outside) begin
                  res_marked_in = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_TRD;
               end
            end else if ((!below_ff && off_ff[GRAIN_SHIFT-1:0] != '0) || size_bad_ff) begin
               res_status_in = ST_MISALIGN;
               state_in      = S_DONE;
            end else if (below_ff) begin
               res_status_in = ST_RANGE;
               state_in      = S_DONE;
            end else begin
               last_in  = LAST_W'(off_ff[ADDR_W-1:GRAIN_SHIFT]) + LAST_W'(nbm1_ff);
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (last_ff >= TOTAL_BITS) begin
               res_status_in = ST_RANGE;
               state_in      = S_DONE;
            end else begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            // Both end words are checked before either is written.
            if ((ram_rdata & m_first) != '0) begin
               res_status_in = ST_ALREADY;
               state_in      = S_DONE;
            end else if (one_word) begin
               ram_we    = 1'b1;
               ram_waddr = fw;
               ram_wdata = ram_rdata | m_first;
               state_in  = S_DONE;
            end else begin
               word1_in  = ram_rdata;
               ram_raddr = lw;
               state_in  = S_RD2;
            end
         end
         S_RD2: begin
            if ((ram_rdata & m2) != '0) begin
               res_status_in = ST_ALREADY;
               state_in      = S_DONE;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = lw;
               ram_wdata = ram_rdata | m2;
               state_in  = S_WR1;
            end
         end
         S_WR1: begin
            ram_we    = 1'b1;
            ram_waddr = fw;
            ram_wdata = word1_ff | m1;
            cnt_in    = fw + 1'b1;
            state_in  = ((fw + 1'b1) == lw) ? S_DONE : S_FILL;
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = ALL_ONES;
            cnt_in    = cnt_ff + 1'b1;
            if ((cnt_ff + 1'b1) == lw) begin
               state_in = S_DONE;
            end
         end
         S_TRD: begin
            res_marked_in = ram_rdata[off_ff[GRAIN_SHIFT+WORD_SHIFT-1:GRAIN_SHIFT]];
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_marked_in = res_marked_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         heap_base_ff  <= '0;
         heap_bytes_ff <= HEAP_BYTES_RESET;
         cnt_ff        <= '0;
         clr_reply_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_base_ff  <= heap_base_in;
         heap_bytes_ff <= heap_bytes_in;
         cnt_ff        <= cnt_in;
         clr_reply_ff  <= clr_reply_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      off_ff        <= off_in;
      below_ff      <= below_in;
      size_bad_ff   <= size_bad_in;
      nbm1_ff       <= nbm1_in;
      last_ff       <= last_in;
      word1_ff      <= word1_in;
      res_marked_ff <= res_marked_in;
      res_status_ff <= res_status_in;
      rsp_marked_ff <= rsp_marked_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: bench/mark_bitmap_range_setter_test.sv
`timescale 1ns / 1ps

module mark_bitmap_range_setter_test;
   import mbrs_pkg::*;

   localparam int BITMAP_WORDS = DEF_BITMAP_WORDS;
   localparam logic [63:0] TOTAL_BITS = 64'(BITMAP_WORDS) * 64'(WORD_BITS);
   localparam int HALF_PERIOD = 6;
   localparam int DRAIN_CYCLES = BITMAP_WORDS + 64;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 88;

   typedef struct packed {
      logic       marked;
      status_type status;
   } bitmap_outcome_t;

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] bytes;
      logic              typed;
      bitmap_outcome_t   outcome;
   } probe_row_t;

   // Directed requests, run with the heap settings left by reset.
   localparam int DIRECTED_COUNT = 23;
   localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{CMD_TEST,  48'h0,              20'd0,      1'b1, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h0,              20'd0,      1'b1, '{1'b0, ST_MISALIGN}},
      '{CMD_MARK,  48'h4,              20'd8,      1'b1, '{1'b0, ST_MISALIGN}},
      '{CMD_MARK,  48'h0,              20'd12,     1'b1, '{1'b0, ST_MISALIGN}},
      '{CMD_MARK,  48'h0,              20'd524288, 1'b1, '{1'b0, ST_OK}},
      '{CMD_TEST,  48'h7FFF8,          20'd0,      1'b1, '{1'b1, ST_OK}},
      '{CMD_MARK,  48'h8,              20'd8,      1'b1, '{1'b0, ST_ALREADY}},
      '{CMD_CLEAR, 48'h0,              20'd0,      1'b1, '{1'b0, ST_OK}},
      '{CMD_TEST,  48'h7FFF8,          20'd0,      1'b1, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h7FFF8,          20'd16,     1'b1, '{1'b0, ST_RANGE}},
      '{CMD_MARK,  48'h7FFF8,          20'd8,      1'b1, '{1'b0, ST_OK}},
      '{CMD_TEST,  48'h7FFFF,          20'd0,      1'b1, '{1'b1, ST_OK}},
      '{CMD_TEST,  48'h80000,          20'd0,      1'b1, '{1'b1, ST_OK}},
      '{CMD_MARK,  48'hFFFF_FFFF_FFF8, 20'd8,      1'b1, '{1'b0, ST_RANGE}},
      '{CMD_MARK,  48'h1F8,            20'd16,     1'b0, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h1000,           20'd4096,   1'b0, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h1FF8,           20'd8,      1'b0, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h10000,          20'd8,      1'b0, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'hFFF8,           20'd528,    1'b0, '{1'b0, ST_OK}},
      '{CMD_TEST,  48'hFFF8,           20'd0,      1'b0, '{1'b0, ST_OK}},
      '{CMD_NOP,   48'hFFFF_FFFF_FFFF, 20'd524288, 1'b1, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h7FFF0,          20'd8,      1'b0, '{1'b0, ST_OK}},
      '{CMD_MARK,  48'h0,              20'd524288, 1'b0, '{1'b0, ST_OK}}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_W-1:0]      csr_wdata;

   mbrs_req_if req_ch ();
   mbrs_rsp_if rsp_ch ();

   mark_bitmap_range_setter #(.BITMAP_WORDS(BITMAP_WORDS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   logic [WORD_BITS-1:0] mark_image [BITMAP_WORDS];
   logic [ADDR_W-1:0]    heap_base_cfg;
   logic [SIZE_W-1:0]    heap_bytes_cfg;
   bitmap_outcome_t      pending_outcomes [$];
   logic [ADDR_W-1:0]    recent_offsets [$];
   bit                   idle_on;
   int unsigned          stall_left = 0;
   int unsigned          failures = 0;
   int unsigned          cmd_count [4];
   int unsigned          mark_status_count [4];
   int unsigned          marked_hits;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [ADDR_W-1:0] random_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic void wipe_mark_image();
      foreach (mark_image[w])
         mark_image[w] = '0;
   endfunction

   // Works out the response to one request and updates the bitmap image.
   function automatic bitmap_outcome_t predict_bitmap_cmd(input cmd_type cmd,
                                                          input logic [ADDR_W-1:0] addr,
                                                          input logic [SIZE_W-1:0] bytes);
      bitmap_outcome_t      outcome;
      logic [ADDR_W-1:0]    offset;
      logic [63:0]          first_bit;
      logic [63:0]          last_bit;
      logic [WORD_BITS-1:0] first_mask;
      logic [WORD_BITS-1:0] last_mask;
      int                   first_word;
      int                   last_word;
      int                   w;
      outcome = '0;
      outcome.status = ST_OK;
      offset = addr - heap_base_cfg;
      case (cmd)
         CMD_MARK: begin
            if (addr >= heap_base_cfg && offset[GRAIN_SHIFT-1:0] != '0) begin
               outcome.status = ST_MISALIGN;
               return outcome;
            end
            if (bytes == '0 || bytes[GRAIN_SHIFT-1:0] != '0) begin
               outcome.status = ST_MISALIGN;
               return outcome;
            end
            first_bit = 64'(offset >> GRAIN_SHIFT);
            last_bit = first_bit + 64'(bytes >> GRAIN_SHIFT) - 64'd1;
            if (addr < heap_base_cfg || last_bit >= TOTAL_BITS) begin
               outcome.status = ST_RANGE;
               return outcome;
            end
            first_word = int'(first_bit >> WORD_SHIFT);
            last_word = int'(last_bit >> WORD_SHIFT);
            first_mask = ALL_ONES << first_bit[WORD_SHIFT-1:0];
            last_mask = ALL_ONES >> (WORD_BITS - 1 - int'(last_bit[WORD_SHIFT-1:0]));
            if (first_word == last_word) begin
               first_mask = first_mask & last_mask;
               last_mask = first_mask;
            end
            // Only the end words are checked for bits already set.
            if ((mark_image[first_word] & first_mask) != '0 ||
                (mark_image[last_word] & last_mask) != '0) begin
               outcome.status = ST_ALREADY;
               return outcome;
            end
            mark_image[first_word] |= first_mask;
            mark_image[last_word] |= last_mask;
            for (w = first_word + 1; w < last_word; w++)
               mark_image[w] = ALL_ONES;
         end
         CMD_TEST: begin
            first_bit = 64'(offset >> GRAIN_SHIFT);
            if (addr < heap_base_cfg || offset >= ADDR_W'(heap_bytes_cfg) ||
                first_bit >= TOTAL_BITS)
               outcome.marked = 1'b1;
            else
               outcome.marked = mark_image[first_bit >> WORD_SHIFT][first_bit[WORD_SHIFT-1:0]];
         end
         CMD_CLEAR: wipe_mark_image();
         default: ;
      endcase
      return outcome;
   endfunction

   task automatic send_request(input cmd_type cmd, input logic [ADDR_W-1:0] addr,
                               input logic [SIZE_W-1:0] bytes, input logic typed,
                               input bitmap_outcome_t typed_outcome);
      bitmap_outcome_t predicted;
      int              gap;
      gap = (idle_on && $urandom_range(3) == 0) ? $urandom_range(1, 15) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.obj_addr <= addr;
      req_ch.obj_bytes <= bytes;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predicted = predict_bitmap_cmd(cmd, addr, bytes);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
      cmd_count[cmd]++;
      if (cmd == CMD_MARK)
         mark_status_count[predicted.status]++;
      if (cmd == CMD_TEST && predicted.marked)
         marked_hits++;
   endtask

   // Heap settings change only once every response is back.
   task automatic write_heap(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_HEAP_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= CSR_HEAP_BYTES;
      csr_wdata <= ADDR_W'(size);
      @(negedge clock);
      csr_we <= 1'b0;
      heap_base_cfg = base;
      heap_bytes_cfg = size;
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(5) == 0) begin
         stall_left <= $urandom_range(14);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      bitmap_outcome_t due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            failures++;
            $display("%0t: response with no request outstanding, marked %0d status %0d",
                     $time, rsp_ch.marked, rsp_ch.status);
         end else begin
            due = pending_outcomes.pop_front();
            if (rsp_ch.marked !== due.marked) begin
               failures++;
               $display("%0t: marked expected %0d, actual %0d", $time, due.marked,
                        rsp_ch.marked);
            end
            if (rsp_ch.status !== due.status) begin
               failures++;
               $display("%0t: status expected %0d, actual %0d", $time, due.status,
                        rsp_ch.status);
            end
         end
      end
   end

   initial begin : stimulus
      cmd_type           cmd;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] bytes;
      int                roll;
      int                pick;
      int                phase;
      int                n;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_HEAP_BASE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_NOP;
      req_ch.obj_addr = '0;
      req_ch.obj_bytes = '0;
      rsp_ch.ready = 1'b0;
      heap_base_cfg = '0;
      heap_bytes_cfg = HEAP_BYTES_RESET;
      wipe_mark_image();
      foreach (cmd_count[i]) begin
         cmd_count[i] = 0;
         mark_status_count[i] = 0;
      end
      marked_hits = 0;
      idle_on = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r])
         send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].bytes,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].outcome);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: write_heap(random_addr() & ~ADDR_W'(7), SIZE_W'($urandom_range(524288)));
            2: write_heap('1, '0);
            3: write_heap(48'hFFFF_FFF8_0000, HEAP_BYTES_RESET);
            4: write_heap(random_addr() | ADDR_W'(1), 20'd262144);
            5: write_heap('0, HEAP_BYTES_RESET);
            default: ;
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Last phase is flat out; others alternate gaps and stalls with flat-out runs.
            idle_on = (phase != PHASES - 1) && ((n / 30) % 3 != 2);
            roll = $urandom_range(99);
            addr = random_addr();
            bytes = SIZE_W'($urandom_range(524288));
            if (roll < 4) begin
               cmd = CMD_CLEAR;
            end else if (roll < 7) begin
               cmd = CMD_NOP;
            end else if (roll < 37) begin
               cmd = CMD_TEST;
               pick = $urandom_range(9);
               if (pick < 5 && recent_offsets.size() != 0)
                  offset = recent_offsets[$urandom_range(recent_offsets.size() - 1)] +
                           ADDR_W'($urandom_range(15));
               else
                  offset = ADDR_W'($urandom_range(600000));
               if (pick != 9)
                  addr = heap_base_cfg + offset;
            end else begin
               cmd = CMD_MARK;
               if ($urandom_range(4) != 0) begin
                  offset = ADDR_W'($urandom_range(65535)) << GRAIN_SHIFT;
                  addr = heap_base_cfg + offset;
                  pick = $urandom_range(49);
                  if (pick == 0)
                     bytes = SIZE_W'($urandom_range(8192, 65536) << GRAIN_SHIFT);
                  else if (pick < 8)
                     bytes = SIZE_W'($urandom_range(17, 2048) << GRAIN_SHIFT);
                  else
                     bytes = SIZE_W'($urandom_range(1, 16) << GRAIN_SHIFT);
                  recent_offsets.push_back(offset);
                  if (recent_offsets.size() > 16)
                     void'(recent_offsets.pop_front());
               end else if ($urandom_range(1) == 0) begin
                  addr = heap_base_cfg + ADDR_W'($urandom_range(600000));
               end
            end
            send_request(cmd, addr, bytes, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d marks (%0d set, %0d misaligned, %0d out of range, %0d overlapping),",
               cmd_count[CMD_MARK], mark_status_count[ST_OK], mark_status_count[ST_MISALIGN],
               mark_status_count[ST_RANGE], mark_status_count[ST_ALREADY]);
      $display("%0d tests (%0d marked), %0d clears and %0d idle commands over six heap settings.",
               cmd_count[CMD_TEST], marked_hits, cmd_count[CMD_CLEAR], cmd_count[CMD_NOP]);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timed out with %0d responses still outstanding.", pending_outcomes.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: mark_bitmap_range_setter.f
src/mbrs_pkg.sv
src/mbrs_req_if.sv
src/mbrs_rsp_if.sv
src/mbrs_ram.sv
src/mark_bitmap_range_setter.sv
bench/mark_bitmap_range_setter_test.sv
